// File: hdl/palette_gradient_color_mapper_top_assert.svh
// assertion macros shared by the palette gradient color mapper modules
`ifndef PALETTE_GRADIENT_COLOR_MAPPER_TOP_ASSERT_SVH
`define PALETTE_GRADIENT_COLOR_MAPPER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PGCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PGCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/pgcm_pkg.sv
// shared types, constants and blend functions of the palette gradient color mapper
`default_nettype none

package pgcm_pkg;

    localparam int NUM_PALETTES = 8;
    localparam int NUM_SEGMENTS = 5;
    localparam int ENTRIES      = NUM_SEGMENTS + 1;
    localparam int PAL_W        = $clog2(NUM_PALETTES);
    localparam int ENT_W        = $clog2(ENTRIES);
    localparam int FRAC_W       = 17;
    localparam int S_W          = FRAC_W + $clog2(NUM_SEGMENTS + 1);
    localparam int QDEPTH       = 4;
    localparam int QIDX_W       = $clog2(QDEPTH);

    localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(65536);

    typedef enum logic [1:0] {
        REG_PALETTE_SELECT        = 2'd0,
        REG_TARGET_PALETTE_SELECT = 2'd1,
        REG_TRANSITION_ENABLE     = 2'd2,
        REG_FADE_WEIGHT           = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]        palette_select;
        logic [2:0]        target_palette_select;
        logic              transition_enable;
        logic [FRAC_W-1:0] fade_weight;
    } cfg_t;

    // one classified item as it travels from front to back
    typedef struct packed {
        logic              is_write;
        logic [2:0]        palette_number;
        logic [2:0]        entry_index;
        logic [23:0]       entry_color;
        logic [ENT_W-1:0]  seg;
        logic [FRAC_W-1:0] frac;
    } item_t;

    // floor(a + (b - a) * f / 65536), f in 0..65536
    function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] b,
                                              input logic [FRAC_W-1:0] f);
        logic signed [8:0]  d;
        logic signed [26:0] acc;
        d   = $signed({1'b0, b}) - $signed({1'b0, a});
        acc = $signed({3'b000, a, 16'h0000}) + d * $signed({1'b0, f});
        return acc[23:16];
    endfunction

    function automatic logic [23:0] blend_rgb(input logic [23:0] c1, input logic [23:0] c2,
                                              input logic [FRAC_W-1:0] f);
        return {blend_chan(c1[23:16], c2[23:16], f),
                blend_chan(c1[15:8], c2[15:8], f),
                blend_chan(c1[7:0], c2[7:0], f)};
    endfunction

endpackage

`default_nettype wire

// File: hdl/palette_gradient_color_mapper_top.sv
// top level of the palette gradient color mapper: config registers and block wiring
//
// s_ channel: one transfer per item. tuser = opcode. opcode 0 maps s_tdata's position
//   (signed Q16, clamped to 0..1.0) to a color, opcode 1 writes entry_color into entry
//   entry_index of palette palette_number and gives no result.
// m_ channel: one color per map item, in input order.
// cfg channel: always ready; cfg_index picks palette select, target palette select,
//   transition enable or fade weight. Write it only while the block is idle.
// path: a map item passes the queue, the palette memory read, the crossfade stage and
//   the segment blend output register before it shows on m_tvalid.
// throughput: one item per cycle unless stalled, writes included; one pipelined back end
// reset: all config registers go to zero and every palette entry reads as black at once
//   through per-entry valid flags; no clearing pass.
// stall: with a color waiting and m_tready low, back pipeline and output hold; the
//   four-entry queue keeps taking items until it fills, then s_tready drops.
`default_nettype none

module palette_gradient_color_mapper_top
    import pgcm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // position[17:0], palette_number[20:18],
                                        // entry_index[23:21], entry_color[47:24]
    input  wire logic        s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // color
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    cfg_t  cfg_reg;
    item_t front_item;
    item_t head;
    logic  full, empty, pop, push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                REG_PALETTE_SELECT:        cfg_reg.palette_select        <= cfg_data[2:0];
                REG_TARGET_PALETTE_SELECT: cfg_reg.target_palette_select <= cfg_data[2:0];
                REG_TRANSITION_ENABLE:     cfg_reg.transition_enable     <= cfg_data[0];
                REG_FADE_WEIGHT:           cfg_reg.fade_weight           <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    pgcm_front u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .item    (front_item)
    );

    pgcm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    pgcm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// File: hdl/pgcm_front.sv
// front end: unpacks input transfers, clamps and scales the position into segment and fraction
`default_nettype none

module pgcm_front
    import pgcm_pkg::*;
(
    input  wire logic [47:0] s_tdata,  // position[17:0], palette_number[20:18],
                                       // entry_index[23:21], entry_color[47:24]
    input  wire logic        s_tuser,  // opcode
    output item_t            item
);

    logic signed [17:0] position;
    logic [FRAC_W-1:0]  p;
    logic [S_W-1:0]     s;
    logic [S_W-17:0]    seg_raw;
    logic [ENT_W-1:0]   seg;

    always_comb begin
        position = $signed(s_tdata[17:0]);
        priority if (position[17]) begin
            p = '0;
        end else if (position[16:0] > Q16_ONE) begin
            p = Q16_ONE;
        end else begin
            p = position[16:0];
        end
        s       = S_W'(p) * S_W'(NUM_SEGMENTS);
        seg_raw = s[S_W-1:16];
        // the end point lands on the last segment with a full fraction
        if (seg_raw >= (S_W-16)'(NUM_SEGMENTS)) begin
            seg = ENT_W'(NUM_SEGMENTS - 1);
        end else begin
            seg = ENT_W'(seg_raw);
        end

        item.is_write       = s_tuser;
        item.palette_number = s_tdata[20:18];
        item.entry_index    = s_tdata[23:21];
        item.entry_color    = s_tdata[47:24];
        item.seg            = seg;
        item.frac           = FRAC_W'(s - (S_W'(seg) << 16));
    end

endmodule

`default_nettype wire

// File: hdl/pgcm_queue.sv
// short fifo between the front and back parts
`default_nettype none

module pgcm_queue
    import pgcm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  item_t      push_item,
    output logic       full,
    input  wire logic  pop,
    output item_t      head,
    output logic       empty
);

    `include "palette_gradient_color_mapper_top_assert.svh"

    item_t             store_reg [QDEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QIDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QIDX_W:0]   count_reg, count_next;

    assign full  = (count_reg == (QIDX_W+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QIDX_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QIDX_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QIDX_W+1)'(push) - (QIDX_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    `PGCM_ASSERT_NOW(a_no_push_full, push, !full, "queue push while full")
    `PGCM_ASSERT_NOW(a_no_pop_empty, pop, !empty, "queue pop while empty")
    `PGCM_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1,
                      "queue count did not grow on push")

endmodule

`default_nettype wire

// File: hdl/pgcm_back.sv
// back end: palette memory, crossfade and segment blend pipeline, output register
`default_nettype none

module pgcm_back
    import pgcm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  cfg_t             cfg,
    input  item_t            head,
    input  wire logic        empty,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata   // color
);

    `include "palette_gradient_color_mapper_top_assert.svh"

    // one bank per palette entry, addressed by palette number
    logic [23:0] palette_mem [ENTRIES][NUM_PALETTES];
    logic [ENTRIES-1:0][NUM_PALETTES-1:0] valid_reg;

    logic              advance;
    logic              do_write, do_map;
    logic              write_ok, cur_ok, tgt_ok;
    logic [PAL_W-1:0]  cur_addr, tgt_addr, wr_addr;

    // stage 1: memory read data
    logic [23:0]       rd_cur_reg [ENTRIES];
    logic [23:0]       rd_tgt_reg [ENTRIES];
    logic [ENTRIES-1:0] vcur_reg, vtgt_reg;
    logic [ENT_W-1:0]  seg1_reg;
    logic [FRAC_W-1:0] frac1_reg;
    logic              v1_reg;

    // stage 2: end colors of the segment
    logic [23:0]       c1_reg, c2_reg;
    logic [FRAC_W-1:0] frac2_reg;
    logic              v2_reg;

    // stage 3: output
    logic [23:0]       color_reg;
    logic              out_valid_reg;

    logic [ENT_W-1:0]  seg_hi;
    logic [23:0]       a_cur, b_cur, a_tgt, b_tgt;
    logic [FRAC_W-1:0] ft;
    logic [23:0]       c1_next, c2_next;

    assign advance  = !out_valid_reg || m_tready;
    assign pop      = !empty && advance;
    assign do_write = pop && head.is_write;
    assign do_map   = pop && !head.is_write;
    assign write_ok = ({1'b0, head.palette_number} < 4'(NUM_PALETTES)) &&
                      ({1'b0, head.entry_index} < 4'(ENTRIES));
    assign cur_ok   = ({1'b0, cfg.palette_select} < 4'(NUM_PALETTES));
    assign tgt_ok   = ({1'b0, cfg.target_palette_select} < 4'(NUM_PALETTES));
    assign cur_addr = PAL_W'(cfg.palette_select);
    assign tgt_addr = PAL_W'(cfg.target_palette_select);
    assign wr_addr  = PAL_W'(head.palette_number);

    always_ff @(posedge aclk) begin
        for (int e = 0; e < ENTRIES; e++) begin
            if (do_write && write_ok && (ENT_W'(e) == ENT_W'(head.entry_index))) begin
                palette_mem[e][wr_addr] <= head.entry_color;
            end
            if (do_map) begin
                rd_cur_reg[e] <= palette_mem[e][cur_addr];
                rd_tgt_reg[e] <= palette_mem[e][tgt_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (do_write && write_ok) begin
            valid_reg[ENT_W'(head.entry_index)][wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_map) begin
            for (int e = 0; e < ENTRIES; e++) begin
                vcur_reg[e] <= valid_reg[e][cur_addr] && cur_ok;
                vtgt_reg[e] <= valid_reg[e][tgt_addr] && tgt_ok;
            end
            seg1_reg  <= head.seg;
            frac1_reg <= head.frac;
        end
    end

    always_comb begin
        seg_hi  = seg1_reg + ENT_W'(1);
        // never-written entries read as black
        a_cur   = vcur_reg[seg1_reg] ? rd_cur_reg[seg1_reg] : 24'h000000;
        b_cur   = vcur_reg[seg_hi] ? rd_cur_reg[seg_hi] : 24'h000000;
        a_tgt   = vtgt_reg[seg1_reg] ? rd_tgt_reg[seg1_reg] : 24'h000000;
        b_tgt   = vtgt_reg[seg_hi] ? rd_tgt_reg[seg_hi] : 24'h000000;
        ft      = (cfg.fade_weight > Q16_ONE) ? Q16_ONE : cfg.fade_weight;
        if (cfg.transition_enable) begin
            c1_next = blend_rgb(a_cur, a_tgt, ft);
            c2_next = blend_rgb(b_cur, b_tgt, ft);
        end else begin
            c1_next = a_cur;
            c2_next = b_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            c1_reg    <= c1_next;
            c2_reg    <= c2_next;
            frac2_reg <= frac1_reg;
            color_reg <= blend_rgb(c1_reg, c2_reg, frac2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg        <= do_map;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = color_reg;

    `PGCM_ASSERT_NEXT(a_write_no_result, do_write, !v1_reg, "write item entered blend pipeline")
    `PGCM_ASSERT_NOW(a_pop_only_on_advance, pop, advance, "queue popped while pipeline stalled")
    `PGCM_ASSERT_NEXT(a_stall_holds_stages, !advance, $stable(v1_reg) && $stable(v2_reg),
                      "pipeline moved during stall")

endmodule

`default_nettype wire

// File: sim/tb_palette_gradient_color_mapper_top.sv
// self-checking testbench for palette_gradient_color_mapper_top: palette writes, maps, crossfades
`timescale 1ns / 1ps

module tb_palette_gradient_color_mapper_top;
    import pgcm_pkg::*;

    typedef enum bit {
        OP_MAP   = 1'b0,
        OP_WRITE = 1'b1
    } pixel_op_t;

    typedef struct {
        pixel_op_t          opcode;
        logic signed [17:0] position;
        logic [2:0]         palette_number;
        logic [2:0]         entry_index;
        logic [23:0]        entry_color;
    } pixel_req_t;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 62;
    localparam int MAX_WAIT      = 8;
    localparam int Q16_UNIT      = 65536;
    localparam int SEG_STEP      = 13107;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;    // position[17:0], palette_number[20:18],
                                    // entry_index[23:21], entry_color[47:24]
    logic        s_tuser   = 1'b0;  // opcode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;           // color
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data  = '0;

    // shadow state of the block
    logic [23:0] palette_model [NUM_PALETTES][ENTRIES];
    logic [2:0]  sel_current;
    logic [2:0]  sel_target;
    logic        crossfade_on;
    logic [16:0] crossfade_frac;

    pixel_req_t  pending_items [$];
    logic [23:0] color_expected [$];
    pixel_req_t  in_flight;
    int          items_queued   = 0;
    int          items_accepted = 0;
    int          error_count    = 0;
    int          cycle_count    = 0;
    int          sender_max_gap = MAX_WAIT;
    int          recv_max_stall = MAX_WAIT;
    int          tx_gap         = 0;
    int          rx_stall       = 0;
    int          rx_hold_left   = 0;
    logic        long_hold_go   = 1'b0;

    palette_gradient_color_mapper_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // floor of a + (b - a) * f / 65536
    function automatic int mix_channel(input int a, input int b, input int f);
        return a + (((b - a) * f) >>> 16);
    endfunction

    function automatic logic [23:0] mix_rgb(input logic [23:0] c1, input logic [23:0] c2,
                                            input int f);
        logic [23:0] mixed;
        for (int k = 0; k < 3; k++) begin
            mixed[8*k +: 8] = 8'(mix_channel(c1[8*k +: 8], c2[8*k +: 8], f));
        end
        return mixed;
    endfunction

    function automatic logic [23:0] entry_of(input int pal, input int idx);
        if (pal >= NUM_PALETTES || idx >= ENTRIES) begin
            return 24'h000000;
        end
        return palette_model[pal][idx];
    endfunction

    function automatic logic [23:0] endpoint_color(input int idx);
        logic [23:0] base;
        int          f;
        base = entry_of(sel_current, idx);
        if (!crossfade_on) begin
            return base;
        end
        f = (crossfade_frac > Q16_UNIT) ? Q16_UNIT : int'(crossfade_frac);
        return mix_rgb(base, entry_of(sel_target, idx), f);
    endfunction

    function automatic logic [23:0] predict_color(input logic signed [17:0] position);
        int p;
        int scaled;
        int seg;
        p = (position < 0) ? 0 : ((position > Q16_UNIT) ? Q16_UNIT : int'(position));
        scaled = p * NUM_SEGMENTS;
        seg = scaled >> 16;
        if (seg >= NUM_SEGMENTS) begin
            seg = NUM_SEGMENTS - 1;
        end
        return mix_rgb(endpoint_color(seg), endpoint_color(seg + 1), scaled - (seg << 16));
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic push_item(input pixel_op_t op, input logic [17:0] pos,
                             input logic [2:0] pal, input logic [2:0] idx,
                             input logic [23:0] color);
        pixel_req_t req;
        req.opcode         = op;
        req.position       = pos;
        req.palette_number = pal;
        req.entry_index    = idx;
        req.entry_color    = color;
        pending_items.push_back(req);
        items_queued++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [16:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PALETTE_SELECT:        sel_current    = val[2:0];
            REG_TARGET_PALETTE_SELECT: sel_target     = val[2:0];
            REG_TRANSITION_ENABLE:     crossfade_on   = val[0];
            REG_FADE_WEIGHT:           crossfade_frac = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [2:0] cur, input logic [2:0] tgt, input logic en,
                              input logic [16:0] frac);
        write_reg(REG_PALETTE_SELECT, 17'(cur));
        write_reg(REG_TARGET_PALETTE_SELECT, 17'(tgt));
        write_reg(REG_TRANSITION_ENABLE, 17'(en));
        write_reg(REG_FADE_WEIGHT, frac);
    endtask

    // wait for all offered items and colors, then let in-flight writes land
    task automatic wait_idle();
        while (items_accepted != items_queued || color_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // sender: one transfer per item, random gap after each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                items_accepted++;
                if (in_flight.opcode == OP_WRITE) begin
                    if (in_flight.palette_number < NUM_PALETTES &&
                        in_flight.entry_index < ENTRIES) begin
                        palette_model[in_flight.palette_number][in_flight.entry_index] =
                            in_flight.entry_color;
                    end
                end else begin
                    color_expected.push_back(predict_color(in_flight.position));
                end
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_flight = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {in_flight.entry_color, in_flight.entry_index,
                                 in_flight.palette_number, in_flight.position};
                    s_tuser  <= in_flight.opcode;
                    tx_gap = $urandom_range(0, sender_max_gap);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge aclk) begin
        if (long_hold_go) begin
            rx_hold_left <= LONG_HOLD;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // receiver: check each color transfer against the oldest prediction
    always @(posedge aclk) begin
        logic [23:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (color_expected.size() == 0) begin
                    flag_mismatch($sformatf("color 0x%06h with none expected", m_tdata));
                end else begin
                    want = color_expected.pop_front();
                    if (m_tdata !== want) begin
                        flag_mismatch($sformatf("color got 0x%06h want 0x%06h",
                                                m_tdata, want));
                    end
                end
                rx_stall = $urandom_range(0, recv_max_stall);
            end
            if (rx_hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_palette_gradient_color_mapper_top NOT OK");
            $finish;
        end
    end

    initial begin
        int         r;
        int         q;
        logic [2:0] pal;
        logic [2:0] idx;
        logic [17:0] pos;

        for (int p = 0; p < NUM_PALETTES; p++) begin
            for (int e = 0; e < ENTRIES; e++) begin
                palette_model[p][e] = 24'h000000;
            end
        end
        sel_current    = '0;
        sel_target     = '0;
        crossfade_on   = 1'b0;
        crossfade_frac = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: untouched table maps to black, then a known palette 0
        push_item(OP_MAP, 18'sd32768, 3'd0, 3'd0, 24'h0);
        push_item(OP_WRITE, 18'h0, 3'd0, 3'd0, 24'h102030);
        push_item(OP_WRITE, 18'h0, 3'd0, 3'd1, 24'hFFFFFF);
        push_item(OP_WRITE, 18'h0, 3'd0, 3'd2, 24'h000000);
        push_item(OP_WRITE, 18'h0, 3'd0, 3'd3, 24'h80FF01);
        push_item(OP_WRITE, 18'h0, 3'd0, 3'd4, 24'h01FF80);
        push_item(OP_WRITE, 18'h0, 3'd0, 3'd5, 24'hC86432);
        // out-of-range entry writes are dropped
        push_item(OP_WRITE, 18'h0, 3'd0, 3'd6, 24'hABCDEF);
        push_item(OP_WRITE, 18'h0, 3'd0, 3'd7, 24'h123456);
        push_item(OP_WRITE, 18'h0, 3'd7, 3'd5, 24'hFEDCBA);
        push_item(OP_MAP, 18'sd0, 3'd7, 3'd7, 24'hFFFFFF);
        push_item(OP_MAP, 18'sd65536, 3'd0, 3'd0, 24'h0);
        push_item(OP_MAP, 18'sd65537, 3'd0, 3'd0, 24'h0);
        push_item(OP_MAP, 18'sd131071, 3'd0, 3'd0, 24'h0);
        push_item(OP_MAP, -18'sd131072, 3'd0, 3'd0, 24'h0);
        push_item(OP_MAP, -18'sd1, 3'd0, 3'd0, 24'h0);
        push_item(OP_MAP, 18'sd65535, 3'd0, 3'd0, 24'h0);
        push_item(OP_MAP, 18'sd13107, 3'd0, 3'd0, 24'h0);
        push_item(OP_MAP, 18'sd13108, 3'd0, 3'd0, 24'h0);
        push_item(OP_MAP, 18'sd32768, 3'd0, 3'd0, 24'h0);
        push_item(OP_MAP, 18'sd52429, 3'd0, 3'd0, 24'h0);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_config(3'd0, 3'd0, 1'b0, 17'd0);
                1: set_config(3'd7, 3'd0, 1'b1, 17'd65536);
                2: set_config(3'd3, 3'd5, 1'b1, 17'd0);
                3: set_config(3'd1, 3'd2, 1'b1, 17'h1FFFF);
                4: set_config(3'd0, 3'd7, 1'b1, 17'd65537);
                default: set_config(3'($urandom), 3'($urandom), 1'($urandom),
                                    17'($urandom_range(0, 70000)));
            endcase
            sender_max_gap = (ph == 1 || ph == 2) ? 0 : MAX_WAIT;
            recv_max_stall = (ph == 1 || ph == 3) ? 0 : MAX_WAIT;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 22) begin
                    idx = (r < 3) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
                    push_item(OP_WRITE, 18'($urandom), 3'($urandom), idx, 24'($urandom));
                end else begin
                    q = $urandom_range(0, 3);
                    case (q)
                        0: pos = 18'($urandom);
                        3: pos = 18'($urandom_range(0, NUM_SEGMENTS) * SEG_STEP
                                     + $urandom_range(0, 6) - 3);
                        default: pos = 18'($urandom_range(0, Q16_UNIT));
                    endcase
                    pal = 3'($urandom);
                    push_item(OP_MAP, pos, pal, 3'($urandom), 24'($urandom));
                end
            end

            // receiver holds off while the sender keeps offering back to back
            if (ph == 2) begin
                @(posedge aclk);
                long_hold_go <= 1'b1;
                @(posedge aclk);
                long_hold_go <= 1'b0;
            end
            wait_idle();
        end

        if (error_count == 0) begin
            $display("tb_palette_gradient_color_mapper_top OK");
        end else begin
            $display("tb_palette_gradient_color_mapper_top NOT OK");
        end
        $finish;
    end

endmodule
